// ===== rtl/core/bwpb_pkg.sv =====
// ----------------------------------------------------------------------------
// bwpb_pkg
// shared types and constants for the brightness weighted pixel blend
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bwpb_pkg;

    // input beat: two laplacian pixels and the guide colour
    typedef struct packed {
        logic signed [15:0] first_ch0;
        logic signed [15:0] first_ch1;
        logic signed [15:0] first_ch2;
        logic signed [15:0] second_ch0;
        logic signed [15:0] second_ch1;
        logic signed [15:0] second_ch2;
        logic        [7:0]  guide_ch0;
        logic        [7:0]  guide_ch1;
        logic        [7:0]  guide_ch2;
    } t_pix_in;

    // result beat
    typedef struct packed {
        logic signed [15:0] blend_ch0;
        logic signed [15:0] blend_ch1;
        logic signed [15:0] blend_ch2;
    } t_blend_out;

    // 3 * 255^2, largest possible sum of squares
    localparam int unsigned GUIDE_DENOM = 195075;
    localparam int unsigned SUMSQ_W     = 18;

    // weight is unsigned q1.16, 0 .. 65536
    localparam int unsigned WEIGHT_W   = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    // t = floor(s * 2^34 / denom) via s * ceil(2^70 / denom) >> 36
    localparam logic [71:0] RECIP_FULL =
        ((72'd1 << 70) + 72'(GUIDE_DENOM - 1)) / 72'(GUIDE_DENOM);
    localparam logic [52:0] RECIP    = RECIP_FULL[52:0];
    localparam logic [26:0] RECIP_LO = RECIP[26:0];
    localparam logic [25:0] RECIP_HI = RECIP[52:27];

    // square root of a 36-bit word, two root bits per stage
    localparam int unsigned SQ_IN_W   = 36;
    localparam int unsigned ROOT_W    = 18;
    localparam int unsigned REM_W     = 20;
    localparam int unsigned SQ_STAGES = 9;

    // multiply, scale, root stages, then weight register
    localparam int unsigned WEIGHT_LAT = SQ_STAGES + 3;
    // input stage, weight unit, product stage, output stage
    localparam int unsigned TOTAL_LAT  = WEIGHT_LAT + 3;

endpackage

// ===== rtl/core/bwpb_weight.sv =====
// ----------------------------------------------------------------------------
// bwpb_weight
// pipelined weight unit: w = round(65536 * sqrt(s / 195075)), halves up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwpb_weight (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [bwpb_pkg::SUMSQ_W-1:0]  i_sumsq,
    output logic                          o_valid,
    output logic [bwpb_pkg::WEIGHT_W-1:0] o_weight
);
    import bwpb_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq_st;

    // one restoring square root step, two radicand bits in
    function automatic t_sq_st sqrt_step(t_sq_st st, logic [1:0] bits);
        logic [REM_W+1:0] x;
        logic [REM_W+1:0] trial;
        t_sq_st           res;
        x     = {st.rem, bits};
        trial = (REM_W+2)'({st.root, 2'b01});
        if (x >= trial) begin
            res.rem  = REM_W'(x - trial);
            res.root = {st.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = REM_W'(x);
            res.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // reciprocal multiply, split in two partial products
    logic        r_va;
    logic [44:0] r_pl;
    logic [43:0] r_ph;

    // root pipeline, entry 0 holds the scaled radicand
    logic                r_sq_v    [SQ_STAGES+1];
    t_sq_st              r_sq_st   [SQ_STAGES+1];
    logic [SQ_IN_W-1:0]  r_sq_t    [SQ_STAGES+1];

    logic                r_vw;
    logic [WEIGHT_W-1:0] r_w;

    logic [44:0]         n_tsum;
    logic [ROOT_W:0]     n_round;

    assign n_tsum  = 45'(r_ph) + 45'(r_pl >> 27);
    assign n_round = (ROOT_W+1)'(r_sq_st[SQ_STAGES].root) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va      <= 1'b0;
            r_sq_v[0] <= 1'b0;
            r_vw      <= 1'b0;
        end else begin
            r_va      <= i_valid;
            r_sq_v[0] <= r_va;
            r_vw      <= r_sq_v[SQ_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl          <= 45'(i_sumsq) * 45'(RECIP_LO);
        r_ph          <= 44'(i_sumsq) * 44'(RECIP_HI);
        r_sq_t[0]     <= SQ_IN_W'(n_tsum >> 9);
        r_sq_st[0]    <= '0;
        r_w           <= WEIGHT_W'(n_round >> 1);
    end

    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_root
        t_sq_st n_mid;
        t_sq_st n_out;

        always_comb begin
            n_mid = sqrt_step(r_sq_st[j], r_sq_t[j][SQ_IN_W-1-4*j -: 2]);
            n_out = sqrt_step(n_mid,      r_sq_t[j][SQ_IN_W-3-4*j -: 2]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j+1] <= 1'b0;
            end else begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_st[j+1] <= n_out;
            r_sq_t[j+1]  <= r_sq_t[j];
        end
    end

    assign o_valid  = r_vw;
    assign o_weight = r_w;

    a_weight_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_weight <= WEIGHT_ONE)
        else $error("weight above one");

    a_weight_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##WEIGHT_LAT o_valid)
        else $error("weight beat lost in pipeline");

    a_weight_white : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_sumsq == SUMSQ_W'(GUIDE_DENOM))
            |-> ##WEIGHT_LAT (o_valid && o_weight == WEIGHT_ONE))
        else $error("white guide does not give full weight");

    a_weight_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_sumsq == '0) |-> ##WEIGHT_LAT (o_valid && o_weight == '0))
        else $error("black guide does not give zero weight");

endmodule

// ===== rtl/core/brightness_weighted_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// brightness_weighted_pixel_blend
// blends two laplacian pixels with a weight set by the guide colour length
//
// usage:
//   - one input beat is taken at each rising edge with start high and busy
//     low; busy is low whenever reset is released, so a pixel can enter in
//     every cycle
//   - each result shows on o_blend for one cycle with o_strobe high;
//     results leave in input order
//   - sustained rate is one pixel per cycle; latency is set by the input stage
//     and the weight path: reciprocal multiply, scaling, nine root stages of
//     two bits each and the weight rounding, then blend product and output stage
//   - the receiver cannot hold results off, so nothing ever backs up
//   - synchronous reset empties the pipeline; beats in flight are dropped
//     and busy stays high while reset is held
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brightness_weighted_pixel_blend (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  bwpb_pkg::t_pix_in       i_pix,
    output logic                    o_strobe,
    output bwpb_pkg::t_blend_out    o_blend
);
    import bwpb_pkg::*;

    // per-pixel payload that waits beside the weight unit
    typedef struct packed {
        logic signed [16:0] d0;
        logic signed [16:0] d1;
        logic signed [16:0] d2;
        logic signed [15:0] b0;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
    } t_mix_pl;

    logic                accept;

    // stage 1: sum of squares and channel differences
    logic                r_v1;
    logic [SUMSQ_W-1:0]  r_s;
    t_mix_pl             r_pl1;
    logic [SUMSQ_W-1:0]  n_s;
    t_mix_pl             n_pl1;

    // delay line matched to the weight unit
    t_mix_pl             r_dly [WEIGHT_LAT];

    logic                w_valid;
    logic [WEIGHT_W-1:0] w_weight;

    // stage 14: w * (a - b)
    logic                r_vp;
    logic signed [33:0]  r_prod [3];
    logic signed [15:0]  r_b    [3];
    logic signed [17:0]  n_wsgn;
    logic signed [16:0]  n_d    [3];
    logic signed [15:0]  n_b    [3];

    // output stage
    logic                r_strobe;
    t_blend_out          r_out;
    logic signed [15:0]  n_blend [3];

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // squares of 8-bit guides fit 16 bits, the sum fits 18
    always_comb begin
        n_s = SUMSQ_W'(16'(i_pix.guide_ch0) * 16'(i_pix.guide_ch0))
            + SUMSQ_W'(16'(i_pix.guide_ch1) * 16'(i_pix.guide_ch1))
            + SUMSQ_W'(16'(i_pix.guide_ch2) * 16'(i_pix.guide_ch2));
        // blend rewritten as b + w * (a - b)
        n_pl1.d0 = 17'(i_pix.first_ch0) - 17'(i_pix.second_ch0);
        n_pl1.d1 = 17'(i_pix.first_ch1) - 17'(i_pix.second_ch1);
        n_pl1.d2 = 17'(i_pix.first_ch2) - 17'(i_pix.second_ch2);
        n_pl1.b0 = i_pix.second_ch0;
        n_pl1.b1 = i_pix.second_ch1;
        n_pl1.b2 = i_pix.second_ch2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s   <= n_s;
        r_pl1 <= n_pl1;
    end

    bwpb_weight u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .i_sumsq  (r_s),
        .o_valid  (w_valid),
        .o_weight (w_weight)
    );

    // payload shift line, no reset needed
    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_pl1;
        for (int i = 1; i < WEIGHT_LAT; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    // weight is at most 2^16, |a - b| below 2^16, product fits 34 bits signed
    always_comb begin
        n_wsgn = $signed({1'b0, w_weight});
        n_d[0] = r_dly[WEIGHT_LAT-1].d0;
        n_d[1] = r_dly[WEIGHT_LAT-1].d1;
        n_d[2] = r_dly[WEIGHT_LAT-1].d2;
        n_b[0] = r_dly[WEIGHT_LAT-1].b0;
        n_b[1] = r_dly[WEIGHT_LAT-1].b1;
        n_b[2] = r_dly[WEIGHT_LAT-1].b2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else begin
            r_vp <= w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= 34'(n_wsgn) * 34'(n_d[k]);
            r_b[k]    <= n_b[k];
        end
    end

    // add b * 65536 plus half, floor shift by 16, clamp as a guard
    always_comb begin
        logic signed [34:0] p;
        logic signed [18:0] q;
        for (int k = 0; k < 3; k++) begin
            p = 35'(r_prod[k]) + $signed({{3{r_b[k][15]}}, r_b[k], 16'd0})
              + 35'sd32768;
            q = p[34:16];
            if (q > 19'sd32767) begin
                n_blend[k] = 16'sh7fff;
            end else if (q < -19'sd32768) begin
                n_blend[k] = 16'sh8000;
            end else begin
                n_blend[k] = q[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.blend_ch0 <= n_blend[0];
        r_out.blend_ch1 <= n_blend[1];
        r_out.blend_ch2 <= n_blend[2];
    end

    assign o_strobe = r_strobe;
    assign o_blend  = r_out;

    a_beat_delivered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##TOTAL_LAT o_strobe)
        else $error("accepted beat did not produce a result");

    a_no_stray_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, TOTAL_LAT))
        else $error("result without a matching input beat");

    a_black_passes_second : assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (o_strobe && $past(i_pix.guide_ch0 == '0 && i_pix.guide_ch1 == '0
                           && i_pix.guide_ch2 == '0, TOTAL_LAT))
            |-> (o_blend.blend_ch0 == $past(i_pix.second_ch0, TOTAL_LAT)
                 && o_blend.blend_ch1 == $past(i_pix.second_ch1, TOTAL_LAT)
                 && o_blend.blend_ch2 == $past(i_pix.second_ch2, TOTAL_LAT)))
        else $error("black guide did not pass the second image through");

endmodule

// ===== tb/brightness_weighted_pixel_blend_test.sv =====
// ----------------------------------------------------------------------------
// brightness_weighted_pixel_blend_test
// self-checking bench for the brightness weighted pixel blend: a directed
// table of corner pixels, then random pixels with random sender gaps, every
// result checked field by field against a typed result or an in-bench blend predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brightness_weighted_pixel_blend_test;

    import bwpb_pkg::*;

    localparam int unsigned RANDOM_BEATS   = 1800;
    localparam int unsigned MAX_GAP        = 16;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    localparam logic signed [15:0] COEF_MIN = 16'sh8000;
    localparam logic signed [15:0] COEF_MAX = 16'sh7fff;
    localparam logic [7:0]         GUIDE_BLACK = 8'd0;
    localparam logic [7:0]         GUIDE_WHITE = 8'd255;

    // one directed row; a row with a known result skips the predictor
    typedef struct {
        t_pix_in    pix;
        bit         known;
        t_blend_out known_out;
    } t_table_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_pix_in    i_pix;
    logic       o_strobe;
    t_blend_out o_blend;

    // results still owed by the block, oldest first
    t_blend_out  blend_q[$];
    t_table_row  corner_rows[$];

    // hand-over from the driver to the monitor for rows with a typed result
    bit          pin_known;
    t_blend_out  pin_out;

    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;

    brightness_weighted_pixel_blend DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pix    (i_pix),
        .o_strobe (o_strobe),
        .o_blend  (o_blend)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // q1.16 weight: largest k in 0..65536 with (2k-1)^2 * denom <= 2^34 * sumsq,
    // which is round-half-up of 65536 * sqrt(sumsq / denom), found bit by bit
    function automatic logic [16:0] weight_of_guide(logic [7:0] g0, logic [7:0] g1,
                                                    logic [7:0] g2);
        longint unsigned sumsq;
        longint unsigned scaled;
        longint unsigned odd;
        logic [16:0]     k;
        logic [16:0]     trial;
        sumsq  = longint'(g0) * longint'(g0) + longint'(g1) * longint'(g1)
               + longint'(g2) * longint'(g2);
        scaled = sumsq << 34;
        k      = '0;
        for (int b = 16; b >= 0; b--) begin
            trial = k | (17'd1 << b);
            if (trial <= WEIGHT_ONE) begin
                odd = 2 * longint'(trial) - 1;
                if (odd * odd * longint'(GUIDE_DENOM) <= scaled) begin
                    k = trial;
                end
            end
        end
        return k;
    endfunction

    // w*a + (1-w)*b, half rounded toward plus infinity, then clamped
    function automatic logic signed [15:0] blend_channel(logic [16:0] w,
                                                         logic signed [15:0] a,
                                                         logic signed [15:0] b);
        longint mix;
        longint q;
        mix = longint'(w) * longint'(a) + (65536 - longint'(w)) * longint'(b) + 32768;
        q   = mix >>> 16;
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return q[15:0];
    endfunction

    function automatic t_blend_out predict_blend(t_pix_in pix);
        t_blend_out  res;
        logic [16:0] w;
        w = weight_of_guide(pix.guide_ch0, pix.guide_ch1, pix.guide_ch2);
        res.blend_ch0 = blend_channel(w, pix.first_ch0, pix.second_ch0);
        res.blend_ch1 = blend_channel(w, pix.first_ch1, pix.second_ch1);
        res.blend_ch2 = blend_channel(w, pix.first_ch2, pix.second_ch2);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: inputs and outputs sampled at the rising edge only
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_blend_out        want;
        logic signed [15:0] want_ch[3];
        logic signed [15:0] got_ch[3];
        if (i_rst_n) begin
            // input beat taken at this edge
            if (start && !busy) begin
                blend_q.insert(blend_q.size(),
                               pin_known ? pin_out : predict_blend(i_pix));
            end
            // result beat; the receiver cannot stall so every strobe counts
            if (o_strobe) begin
                if (blend_q.size() == 0) begin
                    $display("%0t: unexpected result beat %0d %0d %0d", $time,
                             o_blend.blend_ch0, o_blend.blend_ch1, o_blend.blend_ch2);
                    fail_count++;
                end else begin
                    want       = blend_q.pop_front();
                    want_ch[0] = want.blend_ch0;
                    want_ch[1] = want.blend_ch1;
                    want_ch[2] = want.blend_ch2;
                    got_ch[0]  = o_blend.blend_ch0;
                    got_ch[1]  = o_blend.blend_ch1;
                    got_ch[2]  = o_blend.blend_ch2;
                    for (int c = 0; c < 3; c++) begin
                        if (got_ch[c] !== want_ch[c]) begin
                            $display("%0t: blend_ch%0d mismatch expected %0d actual %0d",
                                     $time, c, want_ch[c], got_ch[c]);
                            fail_count++;
                        end
                    end
                end
            end
        end
    end

    // watchdog: too long with neither an input nor a result beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("brightness_weighted_pixel_blend_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_pix_in make_pix(logic signed [15:0] a0, logic signed [15:0] a1,
                                         logic signed [15:0] a2, logic signed [15:0] b0,
                                         logic signed [15:0] b1, logic signed [15:0] b2,
                                         logic [7:0] g0, logic [7:0] g1, logic [7:0] g2);
        t_pix_in pix;
        pix.first_ch0  = a0;
        pix.first_ch1  = a1;
        pix.first_ch2  = a2;
        pix.second_ch0 = b0;
        pix.second_ch1 = b1;
        pix.second_ch2 = b2;
        pix.guide_ch0  = g0;
        pix.guide_ch1  = g1;
        pix.guide_ch2  = g2;
        return pix;
    endfunction

    function automatic t_blend_out make_blend(logic signed [15:0] c0, logic signed [15:0] c1,
                                              logic signed [15:0] c2);
        t_blend_out res;
        res.blend_ch0 = c0;
        res.blend_ch1 = c1;
        res.blend_ch2 = c2;
        return res;
    endfunction

    task automatic add_row(t_pix_in pix, bit known, t_blend_out known_out);
        t_table_row row;
        row.pix       = pix;
        row.known     = known;
        row.known_out = known_out;
        corner_rows.insert(corner_rows.size(), row);
    endtask

    // mostly uniform, now and then one of the corner coefficients
    function automatic logic signed [15:0] rand_coef();
        logic signed [15:0] v;
        v = 16'($urandom());
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
                0: v = COEF_MIN;
                1: v = COEF_MAX;
                2: v = 16'sd0;
                3: v = -16'sd1;
                default: v = 16'sd1;
            endcase
        end
        return v;
    endfunction

    function automatic logic [7:0] rand_guide();
        logic [7:0] g;
        g = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) begin
            g = $urandom_range(0, 1) ? GUIDE_WHITE : GUIDE_BLACK;
        end
        return g;
    endfunction

    function automatic t_pix_in rand_pix();
        t_pix_in pix;
        int unsigned pick;
        pix = make_pix(rand_coef(), rand_coef(), rand_coef(),
                       rand_coef(), rand_coef(), rand_coef(),
                       rand_guide(), rand_guide(), rand_guide());
        // whole black or white guide now and then
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            pix.guide_ch0 = GUIDE_BLACK;
            pix.guide_ch1 = GUIDE_BLACK;
            pix.guide_ch2 = GUIDE_BLACK;
        end else if (pick == 1) begin
            pix.guide_ch0 = GUIDE_WHITE;
            pix.guide_ch1 = GUIDE_WHITE;
            pix.guide_ch2 = GUIDE_WHITE;
        end
        return pix;
    endfunction

    // stay idle through the gap with junk on the bus, then hold the beat until taken
    task automatic drive_beat(t_pix_in pix, int unsigned gap, bit known,
                              t_blend_out known_out);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_pix <= rand_pix();
        end
        @(negedge i_clk);
        pin_known = known;
        pin_out   = known_out;
        start    <= 1'b1;
        i_pix    <= pix;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    // sender holds off until the block has delivered everything owed
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (blend_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_blend_out  none;
        t_pix_in     pix;
        int unsigned gap;
        bit          burst;
        none      = '0;
        pin_known = 1'b0;
        pin_out   = '0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_pix     = '0;

        // corners whose result is plain to see: black guide gives the second
        // image, white guide gives the first, and equal images give that image
        add_row(make_pix(0, 0, 0, 0, 0, 0, GUIDE_BLACK, GUIDE_BLACK, GUIDE_BLACK),
                1, make_blend(0, 0, 0));
        add_row(make_pix(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN,
                         GUIDE_BLACK, GUIDE_BLACK, GUIDE_BLACK),
                1, make_blend(COEF_MIN, COEF_MIN, COEF_MIN));
        add_row(make_pix(COEF_MIN, -1, 12345, COEF_MAX, 1, -12345,
                         GUIDE_BLACK, GUIDE_BLACK, GUIDE_BLACK),
                1, make_blend(COEF_MAX, 1, -12345));
        add_row(make_pix(COEF_MAX, COEF_MIN, 1, COEF_MIN, COEF_MAX, -1,
                         GUIDE_WHITE, GUIDE_WHITE, GUIDE_WHITE),
                1, make_blend(COEF_MAX, COEF_MIN, 1));
        add_row(make_pix(COEF_MIN, COEF_MAX, -1, 0, 0, 0,
                         GUIDE_WHITE, GUIDE_WHITE, GUIDE_WHITE),
                1, make_blend(COEF_MIN, COEF_MAX, -1));
        add_row(make_pix(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                         8'd128, 8'd128, 8'd128),
                1, make_blend(COEF_MAX, COEF_MAX, COEF_MAX));
        // weights in between go through the predictor
        add_row(make_pix(1, -1, 2, 0, 0, -2, 8'd1, GUIDE_BLACK, GUIDE_BLACK), 0, none);
        add_row(make_pix(COEF_MAX, COEF_MIN, 100, COEF_MIN, COEF_MAX, -100,
                         GUIDE_WHITE, GUIDE_BLACK, GUIDE_BLACK), 0, none);
        add_row(make_pix(COEF_MAX, COEF_MIN, 7, COEF_MIN, COEF_MAX, -7,
                         GUIDE_BLACK, GUIDE_WHITE, GUIDE_BLACK), 0, none);
        add_row(make_pix(COEF_MAX, COEF_MIN, 3, COEF_MIN, COEF_MAX, -3,
                         GUIDE_BLACK, GUIDE_BLACK, GUIDE_WHITE), 0, none);
        add_row(make_pix(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                         8'd128, 8'd64, 8'd200), 0, none);
        add_row(make_pix(COEF_MAX, COEF_MIN, 1, COEF_MIN, COEF_MAX, 0,
                         8'd254, GUIDE_WHITE, GUIDE_WHITE), 0, none);
        add_row(make_pix(1, -1, 1, 0, 0, -1, 8'd128, 8'd128, 8'd128), 0, none);
        add_row(make_pix(-1, 1, 3, 0, 0, 4, 8'd147, 8'd147, 8'd147), 0, none);
        add_row(make_pix(16'sh5555, 16'shaaaa, 16'sh00ff, 16'shaaaa, 16'sh5555,
                         16'shff00, 8'haa, 8'h55, 8'hff), 0, none);
        add_row(make_pix(16'sh2aaa, -16'sd21845, 16'sh7f00, 16'sh0f0f, 16'sh7001,
                         16'sh8001, 8'h55, 8'haa, 8'h0f), 0, none);

        // synchronous reset at the start, only once
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, back to back
        foreach (corner_rows[i]) begin
            drive_beat(corner_rows[i].pix, 0, corner_rows[i].known,
                       corner_rows[i].known_out);
        end
        drain_results();

        // random pixels: chunks of back-to-back beats and chunks with gaps
        burst = 1'b0;
        for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0) begin
                burst = ($urandom_range(0, 2) == 0);
            end
            if (n == RANDOM_BEATS / 2) begin
                drain_results();
            end
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            pix = rand_pix();
            drive_beat(pix, gap, 1'b0, none);
        end
        @(negedge i_clk);
        start <= 1'b0;

        // wait for the last results, then a while more for stray beats
        while (blend_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * TOTAL_LAT) @(posedge i_clk);

        if (fail_count == 0 && blend_q.size() == 0) begin
            $display("brightness_weighted_pixel_blend_test OK");
        end else begin
            $display("brightness_weighted_pixel_blend_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bwpb_pkg.sv
rtl/core/bwpb_weight.sv
rtl/core/brightness_weighted_pixel_blend.sv
tb/brightness_weighted_pixel_blend_test.sv
